### hdl/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg: shared constants and types for the SIMD twister word generator
// Ring geometry, reset values of the configuration registers, register
// indexes and the structs passed between the generator modules.
// ----------------------------------------------------------------------------
package stw_pkg;

  // Ring geometry.
  localparam int RING_WORDS = 156;
  localparam int BYTE_SHIFT = 1;
  localparam int LANE_W     = 32;
  localparam int WORD_W     = 4 * LANE_W;
  localparam int LANES      = RING_WORDS * 4;
  localparam int ADDR_W     = $clog2(RING_WORDS);
  localparam int PTR_W      = $clog2(LANES + 1);
  // Offset register holds the raw 8-bit register and also RING_WORDS itself.
  localparam int OFF_W      = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;

  // Seeding multiplier.
  localparam logic [LANE_W-1:0] SEED_MULT = 32'd1812433253;

  // Request modes.
  localparam logic MODE_NEXT = 1'b0;
  localparam logic MODE_SEED = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [7:0]        PICK_OFFSET_RST      = 8'd70;
  localparam logic [4:0]        LANE_LEFT_SHIFT_RST  = 5'd20;
  localparam logic [4:0]        LAST_LEFT_SHIFT_RST  = 5'd23;
  localparam logic [4:0]        LANE_RIGHT_SHIFT_RST = 5'd7;
  localparam logic [LANE_W-1:0] MASK_LANE0_RST       = 32'hffbfffb7;
  localparam logic [LANE_W-1:0] MASK_LANE1_RST       = 32'hfbffff72;
  localparam logic [LANE_W-1:0] MASK_LANE2_RST       = 32'hfeff5fff;
  localparam logic [LANE_W-1:0] MASK_LANE3_RST       = 32'hffbff7ff;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PICK_OFFSET      = 4'd0,
    REG_LANE_LEFT_SHIFT  = 4'd1,
    REG_LAST_LEFT_SHIFT  = 4'd2,
    REG_LANE_RIGHT_SHIFT = 4'd3,
    REG_MASK_LANE0       = 4'd4,
    REG_MASK_LANE1       = 4'd5,
    REG_MASK_LANE2       = 4'd6,
    REG_MASK_LANE3       = 4'd7
  } cfg_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]                   pick_offset;
    logic [4:0]                   lane_left_shift;
    logic [4:0]                   last_left_shift;
    logic [4:0]                   lane_right_shift;
    logic [3:0][LANE_W-1:0]       mask_lane;
  } cfg_t;

  // Status of the generator core.
  typedef struct packed {
    logic             seeded;
    logic [PTR_W-1:0] ptr;
  } status_t;

endpackage

### hdl/stw_if.sv
// ----------------------------------------------------------------------------
// stw_if: handshake channels of the SIMD twister word generator
// Request channel, result word channel and configuration write channel.
// ----------------------------------------------------------------------------

// Request channel: seed or next-word request.
interface stw_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [stw_pkg::LANE_W-1:0] seed_value;

  modport source (output valid, output mode, output seed_value, input ready);
  modport sink   (input valid, input mode, input seed_value, output ready);
endinterface

// Result channel: one random word per next-word request.
interface stw_word_if;
  logic                      valid;
  logic                      ready;
  logic [stw_pkg::LANE_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// Configuration write channel.
interface stw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [stw_pkg::CFG_IDX_W-1:0]  index;
  logic [stw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/simd_twister_random_words_top.sv
// ----------------------------------------------------------------------------
// simd_twister_random_words_top: SIMD twister random word generator
// Ring of 128-bit words in a RAM, seeded and refreshed by a sequencer.
// ----------------------------------------------------------------------------
// Next-word request: one RAM read per word; a new request is taken only once the
//   word is in the result register, which waits while the result is not taken.
// Every 4*RING_WORDS words of a seeded ring a refresh pass over the ring runs first.
// Seed request: no result; each lane passes through a multiply and an add state.
// Reset: synchronous; the ring reads as all zero until the first seed and the
//   configuration registers return to their defaults.
module simd_twister_random_words_top (
  input logic       clk,
  input logic       rst,
  stw_req_if.sink   req,
  stw_word_if.source rsp,
  stw_cfg_if.sink   cfg
);

  stw_pkg::cfg_t                 cfg_regs;
  stw_pkg::status_t              status;
  logic                          ram_we;
  logic [stw_pkg::ADDR_W-1:0]    ram_waddr;
  logic [stw_pkg::WORD_W-1:0]    ram_wdata;
  logic                          ram_rd_en;
  logic [stw_pkg::ADDR_W-1:0]    ram_raddr_a;
  logic [stw_pkg::ADDR_W-1:0]    ram_raddr_b;
  logic [stw_pkg::WORD_W-1:0]    ram_rdata_a;
  logic [stw_pkg::WORD_W-1:0]    ram_rdata_b;

  // Configuration registers.
  stw_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  // Ring store.
  stw_ram #(
    .WIDTH (stw_pkg::WORD_W),
    .DEPTH (stw_pkg::RING_WORDS)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .rd_en   (ram_rd_en),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Sequencer.
  stw_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_regs),
    .req         (req),
    .rsp         (rsp),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_rd_en   (ram_rd_en),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b),
    .status      (status)
  );

  // Ring writes stay inside the ring.
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr < stw_pkg::ADDR_W'(stw_pkg::RING_WORDS)))
    else $error("ring write address beyond the ring");

  // The ring is never written while the block waits for a request.
  a_no_wr_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !req.ready)
    else $error("ring write while idle");

  // The read pointer never passes the exhausted mark.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    status.ptr <= stw_pkg::PTR_W'(stw_pkg::LANES))
    else $error("read pointer beyond the ring");

  // Before the first seed every word handed out is zero.
  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !status.seeded) |-> (rsp.random_word == '0))
    else $error("nonzero word from an unseeded ring");

endmodule

### hdl/stw_ram.sv
// ----------------------------------------------------------------------------
// stw_ram: generic synchronous RAM
// One write port and two read ports, read data registered with a read enable.
// ----------------------------------------------------------------------------
module stw_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 156
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                           rdata_a,
  output logic [WIDTH-1:0]                           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports; data holds while the enable is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### hdl/stw_cfg.sv
// ----------------------------------------------------------------------------
// stw_cfg: configuration registers
// Shift amounts, ring offset and lane masks, written over the config channel.
// ----------------------------------------------------------------------------
module stw_cfg (
  input  logic           clk,
  input  logic           rst,
  stw_cfg_if.sink        cfg,
  output stw_pkg::cfg_t  regs
);

  // The register file takes a write every cycle.
  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pick_offset      <= stw_pkg::PICK_OFFSET_RST;
      regs.lane_left_shift  <= stw_pkg::LANE_LEFT_SHIFT_RST;
      regs.last_left_shift  <= stw_pkg::LAST_LEFT_SHIFT_RST;
      regs.lane_right_shift <= stw_pkg::LANE_RIGHT_SHIFT_RST;
      regs.mask_lane[0]     <= stw_pkg::MASK_LANE0_RST;
      regs.mask_lane[1]     <= stw_pkg::MASK_LANE1_RST;
      regs.mask_lane[2]     <= stw_pkg::MASK_LANE2_RST;
      regs.mask_lane[3]     <= stw_pkg::MASK_LANE3_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        stw_pkg::REG_PICK_OFFSET:      regs.pick_offset      <= cfg.data[7:0];
        stw_pkg::REG_LANE_LEFT_SHIFT:  regs.lane_left_shift  <= cfg.data[4:0];
        stw_pkg::REG_LAST_LEFT_SHIFT:  regs.last_left_shift  <= cfg.data[4:0];
        stw_pkg::REG_LANE_RIGHT_SHIFT: regs.lane_right_shift <= cfg.data[4:0];
        stw_pkg::REG_MASK_LANE0:       regs.mask_lane[0]     <= cfg.data;
        stw_pkg::REG_MASK_LANE1:       regs.mask_lane[1]     <= cfg.data;
        stw_pkg::REG_MASK_LANE2:       regs.mask_lane[2]     <= cfg.data;
        stw_pkg::REG_MASK_LANE3:       regs.mask_lane[3]     <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/stw_core.sv
// ----------------------------------------------------------------------------
// stw_core: sequencer of the SIMD twister word generator
// Seeds the ring lane by lane, refreshes it word by word through the RAM and
// hands out one 32-bit lane per next-word request.
// ----------------------------------------------------------------------------
module stw_core (
  input  logic                              clk,
  input  logic                              rst,
  input  stw_pkg::cfg_t                     cfg,
  stw_req_if.sink                           req,
  stw_word_if.source                        rsp,
  output logic                              ram_we,
  output logic [stw_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [stw_pkg::WORD_W-1:0]        ram_wdata,
  output logic                              ram_rd_en,
  output logic [stw_pkg::ADDR_W-1:0]        ram_raddr_a,
  output logic [stw_pkg::ADDR_W-1:0]        ram_raddr_b,
  input  logic [stw_pkg::WORD_W-1:0]        ram_rdata_a,
  input  logic [stw_pkg::WORD_W-1:0]        ram_rdata_b,
  output stw_pkg::status_t                  status
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SEED_MUL = 10'b0000000010,
    S_SEED_ADD = 10'b0000000100,
    S_REF_OFF  = 10'b0000001000,
    S_REF_PRE0 = 10'b0000010000,
    S_REF_PRE1 = 10'b0000100000,
    S_REF_RD   = 10'b0001000000,
    S_REF_WR   = 10'b0010000000,
    S_READ     = 10'b0100000000,
    S_DELIVER  = 10'b1000000000
  } state_t;

  state_t                                state;
  logic [stw_pkg::PTR_W-1:0]             ptr;
  logic                                  seeded;
  logic [stw_pkg::PTR_W-1:0]             k;
  logic [stw_pkg::LANE_W-1:0]            prev;
  logic [stw_pkg::LANE_W-1:0]            prod;
  logic [2:0][stw_pkg::LANE_W-1:0]       lane_buf;
  logic [stw_pkg::OFF_W-1:0]             b_off;
  logic [stw_pkg::ADDR_W-1:0]            idx;
  logic [stw_pkg::WORD_W-1:0]            c_word;
  logic [stw_pkg::WORD_W-1:0]            d_word;
  logic                                  out_valid;
  logic [stw_pkg::LANE_W-1:0]            out_word;

  logic                                  accept;
  logic                                  out_take;
  logic [stw_pkg::LANE_W-1:0]            seed_val;
  logic [stw_pkg::WORD_W-1:0]            mix_word;
  logic [3:0][stw_pkg::LANE_W-1:0]       rd_lanes;

  // Refresh of word a with offset word b, second newest c and newest d.
  function automatic logic [stw_pkg::WORD_W-1:0] mix(
    input logic [3:0][stw_pkg::LANE_W-1:0] a,
    input logic [3:0][stw_pkg::LANE_W-1:0] b,
    input logic [3:0][stw_pkg::LANE_W-1:0] c,
    input logic [3:0][stw_pkg::LANE_W-1:0] d,
    input stw_pkg::cfg_t                   cf
  );
    logic [stw_pkg::WORD_W-1:0]      xs;
    logic [3:0][stw_pkg::LANE_W-1:0] x;
    logic [3:0][stw_pkg::LANE_W-1:0] r;
    xs = a << (stw_pkg::BYTE_SHIFT * 8);
    x  = xs;
    for (int j = 0; j < 4; j++) begin
      r[j] = a[j] ^ x[j] ^ (b[2'(j + 1)] & cf.mask_lane[j])
           ^ (b[j] << cf.lane_left_shift)
           ^ c[j] ^ (c[j] >> cf.lane_right_shift)
           ^ d[j] ^ (d[j] << cf.last_left_shift);
    end
    return r;
  endfunction

  assign accept    = req.valid && req.ready;
  assign out_take  = out_valid && rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;
  assign status.seeded   = seeded;
  assign status.ptr      = ptr;

  // Seeding lane: product of the previous lane plus the lane index.
  assign seed_val = prod + {{(stw_pkg::LANE_W - stw_pkg::PTR_W){1'b0}}, k};
  assign mix_word = mix(ram_rdata_a, ram_rdata_b, c_word, d_word, cfg);
  assign rd_lanes = ram_rdata_a;

  // RAM port control.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = mix_word;
    ram_rd_en   = 1'b0;
    ram_raddr_a = idx;
    ram_raddr_b = b_off[stw_pkg::ADDR_W-1:0];
    case (state)
      S_SEED_ADD: begin
        ram_we    = (k[1:0] == 2'd3);
        ram_waddr = stw_pkg::ADDR_W'(k >> 2);
        ram_wdata = {seed_val, lane_buf[2], lane_buf[1], lane_buf[0]};
      end
      S_REF_PRE0: begin
        ram_rd_en   = 1'b1;
        ram_raddr_a = stw_pkg::ADDR_W'(stw_pkg::RING_WORDS - 2);
        ram_raddr_b = stw_pkg::ADDR_W'(stw_pkg::RING_WORDS - 1);
      end
      S_REF_RD: begin
        ram_rd_en = 1'b1;
      end
      S_REF_WR: begin
        ram_we = 1'b1;
      end
      S_READ: begin
        ram_rd_en   = 1'b1;
        ram_raddr_a = stw_pkg::ADDR_W'(ptr >> 2);
      end
      default: ;
    endcase
  end

  // Control state: sequencer, read pointer and seeded flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The result register fills from the deliver state and empties when taken.
      if (state == S_DELIVER && (!out_valid || out_take)) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.mode == stw_pkg::MODE_SEED) begin
              state <= S_SEED_MUL;
            end else if (ptr == stw_pkg::PTR_W'(stw_pkg::LANES)) begin
              if (seeded) begin
                state <= S_REF_OFF;
              end else begin
                ptr   <= '0;
                state <= S_READ;
              end
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SEED_MUL: begin
          state <= S_SEED_ADD;
        end
        S_SEED_ADD: begin
          if (k == stw_pkg::PTR_W'(stw_pkg::LANES - 1)) begin
            ptr    <= stw_pkg::PTR_W'(stw_pkg::LANES);
            seeded <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_SEED_MUL;
          end
        end
        S_REF_OFF: begin
          if (b_off < stw_pkg::OFF_W'(stw_pkg::RING_WORDS)) begin
            state <= S_REF_PRE0;
          end
        end
        S_REF_PRE0: begin
          state <= S_REF_PRE1;
        end
        S_REF_PRE1: begin
          state <= S_REF_RD;
        end
        S_REF_RD: begin
          state <= S_REF_WR;
        end
        S_REF_WR: begin
          if (idx == stw_pkg::ADDR_W'(stw_pkg::RING_WORDS - 1)) begin
            ptr   <= '0;
            state <= S_READ;
          end else begin
            state <= S_REF_RD;
          end
        end
        S_READ: begin
          state <= S_DELIVER;
        end
        S_DELIVER: begin
          if (!out_valid || out_take) begin
            ptr   <= ptr + 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: seeding lanes, refresh operands and the result word.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        prev        <= req.seed_value;
        lane_buf[0] <= req.seed_value;
        k           <= stw_pkg::PTR_W'(1);
        b_off       <= stw_pkg::OFF_W'(cfg.pick_offset);
      end
      S_SEED_MUL: begin
        prod <= stw_pkg::SEED_MULT * (prev ^ (prev >> 30));
      end
      S_SEED_ADD: begin
        prev <= seed_val;
        if (k[1:0] != 2'd3) begin
          lane_buf[k[1:0]] <= seed_val;
        end
        k <= k + 1'b1;
      end
      S_REF_OFF: begin
        // Reduce the offset modulo the ring size, one subtraction a cycle.
        if (b_off >= stw_pkg::OFF_W'(stw_pkg::RING_WORDS)) begin
          b_off <= b_off - stw_pkg::OFF_W'(stw_pkg::RING_WORDS);
        end
      end
      S_REF_PRE1: begin
        c_word <= ram_rdata_a;
        d_word <= ram_rdata_b;
        idx    <= '0;
      end
      S_REF_WR: begin
        c_word <= d_word;
        d_word <= mix_word;
        idx    <= idx + 1'b1;
        if (b_off == stw_pkg::OFF_W'(stw_pkg::RING_WORDS - 1)) begin
          b_off <= '0;
        end else begin
          b_off <= b_off + 1'b1;
        end
      end
      S_DELIVER: begin
        if (!out_valid || out_take) begin
          // An unseeded ring is all zero.
          out_word <= seeded ? rd_lanes[ptr[1:0]] : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the SIMD twister random word generator
// Seeds the ring, asks for words under several register settings and
// compares every returned word with a cycle-free model of the ring, with
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import stw_pkg::*;

  typedef logic [LANE_W-1:0] lane_t;

  localparam int    PERIOD         = 12;
  localparam int    RESET_CYCLES   = 9;
  localparam int    IDLE_PERCENT   = 21;
  localparam int    SEED_CYCLES    = 2 * (LANES - 1) + 1;
  localparam int    REFRESH_CYCLES = 2 * RING_WORDS + 5;
  localparam int    SETTLE_CYCLES  = SEED_CYCLES + 64;
  localparam int    LONG_STALL     = 300;
  localparam int    WATCHDOG_LIMIT =
    3 * (SEED_CYCLES + REFRESH_CYCLES + LONG_STALL + SETTLE_CYCLES);

  localparam cfg_t DEFAULT_SETTINGS = '{
    pick_offset:      PICK_OFFSET_RST,
    lane_left_shift:  LANE_LEFT_SHIFT_RST,
    last_left_shift:  LAST_LEFT_SHIFT_RST,
    lane_right_shift: LANE_RIGHT_SHIFT_RST,
    mask_lane:        {MASK_LANE3_RST, MASK_LANE2_RST, MASK_LANE1_RST, MASK_LANE0_RST}
  };

  logic clk = 1'b0;
  logic rst;

  stw_req_if  req_ch ();
  stw_word_if word_ch ();
  stw_cfg_if  cfg_ch ();

  simd_twister_random_words_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (word_ch),
    .cfg (cfg_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Shadow of the generator state and its registers.
  lane_t       model_ring [RING_WORDS][4];
  int unsigned lane_ptr;
  cfg_t        model_cfg;
  lane_t       pending_words [$];

  int   errors = 0;
  int   quiet_cycles = 0;
  logic steady_flow;
  logic stall_toggle;
  logic stall_seen;
  int   stall_left;

  task automatic note_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic void reset_model();
    foreach (model_ring[w, l]) model_ring[w][l] = '0;
    lane_ptr = 0;
    model_cfg = DEFAULT_SETTINGS;
    pending_words.delete();
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                         input logic [CFG_DATA_W-1:0] data);
    case (index)
      REG_PICK_OFFSET:      model_cfg.pick_offset = data[7:0];
      REG_LANE_LEFT_SHIFT:  model_cfg.lane_left_shift = data[4:0];
      REG_LAST_LEFT_SHIFT:  model_cfg.last_left_shift = data[4:0];
      REG_LANE_RIGHT_SHIFT: model_cfg.lane_right_shift = data[4:0];
      REG_MASK_LANE0:       model_cfg.mask_lane[0] = data;
      REG_MASK_LANE1:       model_cfg.mask_lane[1] = data;
      REG_MASK_LANE2:       model_cfg.mask_lane[2] = data;
      REG_MASK_LANE3:       model_cfg.mask_lane[3] = data;
      default: ;
    endcase
  endfunction

  // Fill every lane from the seed; the read pointer ends up exhausted.
  function automatic void seed_model(input lane_t seed);
    lane_t p;
    p = seed;
    model_ring[0][0] = p;
    for (int k = 1; k < LANES; k++) begin
      p = SEED_MULT * (p ^ (p >> 30)) + lane_t'(k);
      model_ring[k / 4][k % 4] = p;
    end
    lane_ptr = LANES;
  endfunction

  // One full pass over the ring in ring order, in place.
  function automatic void refresh_model();
    int unsigned        off;
    lane_t              b [4];
    lane_t              c [4];
    lane_t              d [4];
    logic [WORD_W-1:0]  whole;
    logic [WORD_W-1:0]  shifted;
    off = model_cfg.pick_offset % RING_WORDS;
    for (int i = 0; i < RING_WORDS; i++) begin
      b = model_ring[(i + off) % RING_WORDS];
      c = model_ring[(i + RING_WORDS - 2) % RING_WORDS];
      d = model_ring[(i + RING_WORDS - 1) % RING_WORDS];
      whole = {model_ring[i][3], model_ring[i][2], model_ring[i][1], model_ring[i][0]};
      shifted = whole << (8 * BYTE_SHIFT);
      for (int j = 0; j < 4; j++) begin
        model_ring[i][j] = model_ring[i][j] ^ shifted[LANE_W*j +: LANE_W]
          ^ (b[(j + 1) % 4] & model_cfg.mask_lane[j])
          ^ (b[j] << model_cfg.lane_left_shift)
          ^ c[j] ^ (c[j] >> model_cfg.lane_right_shift)
          ^ d[j] ^ (d[j] << model_cfg.last_left_shift);
      end
    end
  endfunction

  function automatic lane_t next_model_word();
    lane_t w;
    if (lane_ptr >= LANES) begin
      refresh_model();
      lane_ptr = 0;
    end
    w = model_ring[lane_ptr / 4][lane_ptr % 4];
    lane_ptr++;
    return w;
  endfunction

  // Track accepted requests and register writes, check every returned word,
  // and stop the run if nothing moves for too long.
  always @(posedge clk) begin : monitor
    lane_t want;
    logic  moved;
    if (rst) begin
      reset_model();
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        if (req_ch.mode == MODE_SEED) seed_model(req_ch.seed_value);
        else pending_words.push_back(next_model_word());
      end
      if (word_ch.valid && word_ch.ready) begin
        moved = 1'b1;
        if (pending_words.size() == 0) begin
          note_error($sformatf("word %h with no request outstanding",
                               word_ch.random_word));
        end else begin
          want = pending_words.pop_front();
          if (word_ch.random_word !== want)
            note_error($sformatf("random_word %h, want %h", word_ch.random_word, want));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        apply_register(cfg_ch.index, cfg_ch.data);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Output side: random idling, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      word_ch.ready <= 1'b0;
      stall_left <= 0;
      stall_seen <= stall_toggle;
    end else if (stall_seen != stall_toggle) begin
      stall_seen <= stall_toggle;
      stall_left <= LONG_STALL;
      word_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      word_ch.ready <= 1'b0;
    end else begin
      word_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Offer one request word and wait for it to be taken. Valid stays high
  // afterwards so back-to-back words need no extra edge.
  task automatic send_request(input logic mode_bit, input lane_t seed);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode_bit;
    req_ch.seed_value <= seed;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write the full register set, junk in the unused bits, then one write
  // to an index past the last register, which must change nothing.
  task automatic load_settings(input cfg_t s);
    write_register(REG_PICK_OFFSET, {24'($urandom), s.pick_offset});
    write_register(REG_LANE_LEFT_SHIFT, {27'($urandom), s.lane_left_shift});
    write_register(REG_LAST_LEFT_SHIFT, {27'($urandom), s.last_left_shift});
    write_register(REG_LANE_RIGHT_SHIFT, {27'($urandom), s.lane_right_shift});
    write_register(REG_MASK_LANE0, s.mask_lane[0]);
    write_register(REG_MASK_LANE1, s.mask_lane[1]);
    write_register(REG_MASK_LANE2, s.mask_lane[2]);
    write_register(REG_MASK_LANE3, s.mask_lane[3]);
    write_register(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_MASK_LANE3 + 1)),
                   $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain all words, then give a trailing seed time to finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    case ($urandom_range(3))
      0:       s.pick_offset = 8'd0;
      1:       s.pick_offset = 8'd155;
      2:       s.pick_offset = 8'd255;
      default: s.pick_offset = 8'($urandom);
    endcase
    s.lane_left_shift = 5'($urandom);
    s.last_left_shift = 5'($urandom);
    s.lane_right_shift = 5'($urandom);
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(3))
        0:       s.mask_lane[j] = '0;
        1:       s.mask_lane[j] = '1;
        default: s.mask_lane[j] = $urandom;
      endcase
    end
    return s;
  endfunction

  // Mostly a seed followed by a run of reads; sometimes reads carry on
  // from the old state, sometimes a seed is overwritten before any read.
  task automatic run_traffic(input int count);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0: ;
        1: begin
          send_request(MODE_SEED, $urandom);
          send_request(MODE_SEED, $urandom);
          sent += 2;
        end
        default: begin
          send_request(MODE_SEED, $urandom);
          sent++;
        end
      endcase
      run = $urandom_range(30, 1);
      repeat (run) send_request(MODE_NEXT, $urandom);
      sent += run;
    end
  endtask

  // Reads before any seed return zeros, also when the read pointer wraps past
  // the end of the all-zero ring; the ignored seed field carries noise.
  task automatic test_unseeded_ring();
    repeat (LANES + 6) send_request(MODE_NEXT, $urandom);
  endtask

  // Seed extremes, back-to-back seeds and an ignored seed field.
  task automatic test_seed_extremes();
    send_request(MODE_SEED, '0);
    repeat (3) send_request(MODE_NEXT, '0);
    send_request(MODE_SEED, '1);
    repeat (3) send_request(MODE_NEXT, '1);
    send_request(MODE_SEED, 32'h8000_0001);
    send_request(MODE_SEED, 32'h0000_0001);
    repeat (2) send_request(MODE_NEXT, '1);
    send_request(MODE_SEED, 32'h7fff_fffe);
    send_request(MODE_NEXT, 32'h5555_5555);
    send_request(MODE_NEXT, 32'haaaa_aaaa);
  endtask

  // All-zero and all-one registers, and offsets at and past the ring end.
  task automatic test_register_extremes();
    cfg_t corner [5];
    corner[0] = '0;
    corner[1] = '1;
    corner[2] = DEFAULT_SETTINGS;
    corner[2].pick_offset = 8'd155;
    corner[3] = DEFAULT_SETTINGS;
    corner[3].pick_offset = 8'(RING_WORDS);
    corner[4] = DEFAULT_SETTINGS;
    corner[4].pick_offset = 8'd1;
    corner[4].lane_left_shift = 5'd31;
    corner[4].last_left_shift = 5'd31;
    corner[4].lane_right_shift = 5'd0;
    foreach (corner[c]) begin
      settle();
      load_settings(corner[c]);
      run_traffic(40);
    end
  endtask

  // Random register sets; one phase runs with no idling on either side.
  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      settle();
      load_settings(random_settings());
      steady_flow <= (p == 1);
      run_traffic(60);
    end
    steady_flow <= 1'b0;
  endtask

  // Long output hold-off while requests keep coming, then enough reads to
  // run the pointer past the end of the ring a second time.
  task automatic test_output_backpressure();
    settle();
    send_request(MODE_SEED, $urandom);
    repeat (4) send_request(MODE_NEXT, $urandom);
    stall_toggle <= ~stall_toggle;
    repeat (LANES + 12) send_request(MODE_NEXT, $urandom);
  endtask

  initial begin
    rst <= 1'b1;
    steady_flow <= 1'b0;
    stall_toggle <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_NEXT;
    req_ch.seed_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_PICK_OFFSET;
    cfg_ch.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unseeded_ring();
    test_seed_extremes();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    settle();

    if (pending_words.size() != 0)
      note_error($sformatf("%0d words never returned", pending_words.size()));
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
